>>> hdl/sss_pkg.sv
`default_nettype none

package sss_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    RegRefreshReload = 3'd0,
    RegBlinkReload   = 3'd1,
    RegSelHundreds   = 3'd2,
    RegSelTens       = 3'd3,
    RegSelUnits      = 3'd4,
    RegBlankCode     = 3'd5
  } sss_reg_e;

  // Digit positions in scan order
  typedef enum logic [1:0] {
    PosUnits    = 2'd0,
    PosTens     = 2'd1,
    PosHundreds = 2'd2,
    PosUnused   = 2'd3
  } sss_pos_e;

  localparam int unsigned SymbolCount = 25;
  localparam int unsigned TableDepth  = 25;

  // Segment patterns, bits dp g f e d c b a
  localparam logic [7:0] SegTable [TableDepth] = '{
    8'h00, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67,
    8'h3F, 8'h80, 8'h40, 8'h63, 8'h73, 8'h79, 8'h58, 8'h74, 8'h86, 8'h6D,
    8'h5F, 8'h78, 8'h50, 8'h6F, 8'h54
  };

  typedef struct packed {
    logic [7:0] refresh_reload;
    logic [7:0] blink_reload;
    logic [7:0] sel_hundreds;
    logic [7:0] sel_tens;
    logic [7:0] sel_units;
    logic [7:0] blank_code;
  } sss_cfg_t;

  // One refreshed digit on its way to the encoder
  typedef struct packed {
    logic [7:0] code;
    logic [7:0] sel;
    logic [1:0] pos;
  } sss_beat_t;

  function automatic logic [7:0] seg_lookup(input logic [7:0] code);
    logic [7:0] seg;
    seg = 8'h00;
    if (({1'b0, code} < 9'(SymbolCount)) && ({1'b0, code} < 9'(TableDepth))) begin
      seg = SegTable[code[4:0]];
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sss_cfg.sv
`default_nettype none

module sss_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [2:0]    idx_i,
  input  wire logic [7:0]    data_i,
  output sss_pkg::sss_cfg_t  cfg_o
);
  import sss_pkg::*;

  sss_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        RegRefreshReload: cfg_d.refresh_reload = data_i;
        RegBlinkReload:   cfg_d.blink_reload   = data_i;
        RegSelHundreds:   cfg_d.sel_hundreds   = data_i;
        RegSelTens:       cfg_d.sel_tens       = data_i;
        RegSelUnits:      cfg_d.sel_units      = data_i;
        RegBlankCode:     cfg_d.blank_code     = data_i;
        default:          cfg_d = cfg_q;  // drop writes past the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{refresh_reload: 8'd2, blink_reload: 8'd50, sel_hundreds: 8'd4,
                 sel_tens: 8'd2, sel_units: 8'd1, blank_code: 8'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hdl/sss_scan.sv
`default_nettype none

module sss_scan (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  sss_pkg::sss_cfg_t  cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    hundreds_code_i,
  input  wire logic [7:0]    tens_code_i,
  input  wire logic [7:0]    units_code_i,
  input  wire logic [7:0]    blink_mask_i,
  output logic               beat_valid_o,
  input  wire logic          beat_ready_i,
  output sss_pkg::sss_beat_t beat_o
);
  import sss_pkg::*;

  logic [1:0] scan_pos_q, scan_pos_d;
  logic [7:0] refresh_cnt_q, refresh_cnt_d;
  logic [7:0] blink_cnt_q, blink_cnt_d;
  logic       blink_on_q, blink_on_d;
  logic       beat_valid_q, beat_valid_d;
  sss_beat_t  beat_q, beat_d;

  logic       accept;
  logic       emit;
  logic       blinking;
  logic       phase_on;
  logic [7:0] code;
  logic [7:0] sel;

  assign in_ready_o = !beat_valid_q || beat_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    code = units_code_i;
    sel  = cfg_i.sel_units;
    unique case (scan_pos_q)
      PosUnits: begin
        code = units_code_i;
        sel  = cfg_i.sel_units;
      end
      PosTens: begin
        code = tens_code_i;
        sel  = cfg_i.sel_tens;
      end
      PosHundreds: begin
        code = hundreds_code_i;
        sel  = cfg_i.sel_hundreds;
      end
      default: begin
        code = units_code_i;
        sel  = cfg_i.sel_units;
      end
    endcase
  end

  assign blinking = |(blink_mask_i & sel);

  always_comb begin
    scan_pos_d    = scan_pos_q;
    refresh_cnt_d = refresh_cnt_q;
    blink_cnt_d   = blink_cnt_q;
    blink_on_d    = blink_on_q;
    emit          = 1'b0;
    phase_on      = blink_on_q;
    if (accept) begin
      if (refresh_cnt_q != 8'd0) begin
        refresh_cnt_d = refresh_cnt_q - 8'd1;
      end else begin
        refresh_cnt_d = cfg_i.refresh_reload;
        if (scan_pos_q == PosUnused) begin
          scan_pos_d = PosUnits;
        end else begin
          emit       = 1'b1;
          scan_pos_d = (scan_pos_q == PosHundreds) ? PosUnits : scan_pos_q + 2'd1;
          if (blinking) begin
            if (blink_cnt_q == 8'd0) begin
              blink_on_d  = !blink_on_q;
              phase_on    = !blink_on_q;
              blink_cnt_d = cfg_i.blink_reload;
            end else begin
              blink_cnt_d = blink_cnt_q - 8'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    beat_valid_d = beat_valid_q && !beat_ready_i;
    beat_d       = beat_q;
    if (accept) begin
      beat_valid_d = emit;
    end
    if (emit) begin
      beat_d.code = (blinking && !phase_on) ? cfg_i.blank_code : code;
      beat_d.sel  = sel;
      beat_d.pos  = scan_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_pos_q    <= PosUnits;
      refresh_cnt_q <= 8'd0;
      blink_cnt_q   <= 8'd0;
      blink_on_q    <= 1'b0;
      beat_valid_q  <= 1'b0;
    end else begin
      scan_pos_q    <= scan_pos_d;
      refresh_cnt_q <= refresh_cnt_d;
      blink_cnt_q   <= blink_cnt_d;
      blink_on_q    <= blink_on_d;
      beat_valid_q  <= beat_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign beat_valid_o = beat_valid_q;
  assign beat_o       = beat_q;

endmodule

`default_nettype wire

>>> hdl/sss_encode.sv
`default_nettype none

module sss_encode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          beat_valid_i,
  output logic               beat_ready_o,
  input  sss_pkg::sss_beat_t beat_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         select_byte_o,
  output logic [7:0]         segment_byte_o,
  output logic [1:0]         digit_position_o
);
  import sss_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [7:0] select_q, select_d;
  logic [7:0] segment_q, segment_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] seg;
  logic       load;

  assign beat_ready_o = !out_valid_q || out_ready_i;
  assign load         = beat_valid_i && beat_ready_o;
  assign seg          = seg_lookup(beat_i.code);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    select_d    = select_q;
    segment_d   = segment_q;
    pos_d       = pos_q;
    if (load) begin
      out_valid_d = 1'b1;
      // segment bit 7 rides in bit 0 of the select byte
      select_d    = {beat_i.sel[7:1], seg[7]};
      segment_d   = {seg[6:0], 1'b0};
      pos_d       = beat_i.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    select_q  <= select_d;
    segment_q <= segment_d;
    pos_q     <= pos_d;
  end

  assign out_valid_o      = out_valid_q;
  assign select_byte_o    = select_q;
  assign segment_byte_o   = segment_q;
  assign digit_position_o = pos_q;

endmodule

`default_nettype wire

>>> hdl/seven_segment_scan_blink.sv
`default_nettype none
// Channel  | Direction | Handshake            | Beat contents
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid_i/in_ready_o | hundreds, tens, units codes, blink mask
// out      | output    | out_valid_o/out_ready_i | select byte, segment byte, digit position
// cfg      | input     | cfg_we_i (no wait)   | cfg_idx_i, cfg_data_i
//
// One tick is accepted per cycle while in_ready_o is high. A tick that refreshes a digit
// passes its result through the scan register, which holds the chosen code, and then the
// output register, which holds the packed bytes. Reset clears the scan position, both
// countdowns and the blink phase, and loads the configuration registers with their
// defaults. A stalled output backs up through both registers before in_ready_o drops.

module seven_segment_scan_blink (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] hundreds_code_i,
  input  wire logic [7:0] tens_code_i,
  input  wire logic [7:0] units_code_i,
  input  wire logic [7:0] blink_mask_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      select_byte_o,
  output logic [7:0]      segment_byte_o,
  output logic [1:0]      digit_position_o
);
  import sss_pkg::*;

  sss_cfg_t  cfg;
  sss_beat_t beat;
  logic      beat_valid;
  logic      beat_ready;

  sss_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  sss_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .hundreds_code_i (hundreds_code_i),
    .tens_code_i     (tens_code_i),
    .units_code_i    (units_code_i),
    .blink_mask_i    (blink_mask_i),
    .beat_valid_o    (beat_valid),
    .beat_ready_i    (beat_ready),
    .beat_o          (beat)
  );

  sss_encode u_encode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .beat_valid_i     (beat_valid),
    .beat_ready_o     (beat_ready),
    .beat_i           (beat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .select_byte_o    (select_byte_o),
    .segment_byte_o   (segment_byte_o),
    .digit_position_o (digit_position_o)
  );

  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_position_o != PosUnused)
    else $error("unused digit position reached the output");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (beat_valid && !beat_ready && out_valid_o))
    else $error("input stalled without a full pipeline");

  a_beat_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_valid && beat_ready) |=> out_valid_o)
    else $error("scan beat lost on its way to the output");

endmodule

`default_nettype wire

>>> sim/tb_seven_segment_scan_blink.sv
`timescale 1ns / 100ps

module tb_seven_segment_scan_blink;
  import sss_pkg::*;

  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned Limit       = 200000;
  localparam int unsigned GlyphCount  = 25;

  // Spare register indexes, outside the register map
  localparam logic [2:0] RegSpare6 = 3'd6;
  localparam logic [2:0] RegSpare7 = 3'd7;

  // Segment patterns, dp g f e d c b a
  localparam logic [7:0] Glyphs [GlyphCount] = '{
    8'h00, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67,
    8'h3F, 8'h80, 8'h40, 8'h63, 8'h73, 8'h79, 8'h58, 8'h74, 8'h86, 8'h6D,
    8'h5F, 8'h78, 8'h50, 8'h6F, 8'h54
  };

  typedef struct packed {
    logic [7:0] sel_byte;
    logic [7:0] seg_byte;
    logic [1:0] pos;
  } digit_t;

  typedef enum logic [1:0] {
    RowTick,
    RowTickPin,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [2:0] reg_idx;
    logic [7:0] reg_data;
    logic [7:0] hundreds;
    logic [7:0] tens;
    logic [7:0] units;
    logic [7:0] mask;
    digit_t     want;
  } dir_row_t;

  localparam int NumRows = 32;

  localparam dir_row_t DirRows [NumRows] = '{
    '{RowTickPin, 3'd0, 8'h00, 8'd3, 8'd10, 8'd1, 8'h00, '{8'h00, 8'h0C, PosUnits}},
    '{RowTick, 3'd0, 8'h00, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTick, 3'd0, 8'h00, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd9, 8'd10, 8'd8, 8'h00, '{8'h02, 8'h7E, PosTens}},
    '{RowCfg, RegRefreshReload, 8'h00, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTick, 3'd0, 8'h00, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTick, 3'd0, 8'h00, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'hFF, 8'd0, 8'd0, 8'h00, '{8'h04, 8'h00, PosHundreds}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd0, 8'd11, 8'h00, '{8'h01, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd18, 8'd0, 8'h00, '{8'h03, 8'h0C, PosTens}},
    '{RowTickPin, 3'd0, 8'h00, 8'd24, 8'd0, 8'd0, 8'h00, '{8'h04, 8'hA8, PosHundreds}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd0, 8'd25, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowCfg, RegBlinkReload, 8'h00, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowCfg, RegBlankCode, 8'd11, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd5, 8'd0, 8'hFF, '{8'h02, 8'hDA, PosTens}},
    '{RowTickPin, 3'd0, 8'h00, 8'd7, 8'd0, 8'd0, 8'h02, '{8'h04, 8'h0E, PosHundreds}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd0, 8'd8, 8'h01, '{8'h01, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd3, 8'd0, 8'h02, '{8'h02, 8'h9E, PosTens}},
    '{RowCfg, RegSelUnits, 8'hFF, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowCfg, RegSelTens, 8'h00, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowCfg, RegSelHundreds, 8'h80, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowCfg, RegBlankCode, 8'hFF, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowCfg, RegBlinkReload, 8'hFF, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd1, 8'd0, 8'd0, 8'h80, '{8'h80, 8'h00, PosHundreds}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd0, 8'd2, 8'h7F, '{8'hFE, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd4, 8'd0, 8'hFF, '{8'h00, 8'hCC, PosTens}},
    '{RowTickPin, 3'd0, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'h55, '{8'h80, 8'h00, PosHundreds}},
    '{RowCfg, RegSpare6, 8'h03, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowCfg, RegSpare7, 8'h03, 8'd0, 8'd0, 8'd0, 8'h00, '{8'h00, 8'h00, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd0, 8'd9, 8'h00, '{8'hFE, 8'hCE, PosUnits}},
    '{RowTickPin, 3'd0, 8'h00, 8'd0, 8'd6, 8'd0, 8'h00, '{8'h00, 8'hFA, PosTens}},
    '{RowTickPin, 3'd0, 8'h00, 8'd12, 8'd0, 8'd0, 8'h00, '{8'h80, 8'h80, PosHundreds}}
  };

  logic       clk_i;
  logic       rst_ni           = 1'b0;
  logic       cfg_we_i         = 1'b0;
  logic [2:0] cfg_idx_i        = '0;
  logic [7:0] cfg_data_i       = '0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic [7:0] hundreds_code_i  = '0;
  logic [7:0] tens_code_i      = '0;
  logic [7:0] units_code_i     = '0;
  logic [7:0] blink_mask_i     = '0;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [7:0] select_byte_o;
  logic [7:0] segment_byte_o;
  logic [1:0] digit_position_o;

  // Typed-in expectation riding along with the beat it belongs to
  bit     pin_on    = 1'b0;
  digit_t pin_digit = '0;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  bit          hold_req  = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int          mismatches  = 0;

  // Shadow state of the display driver
  logic [7:0] cfg_refresh, cfg_blink, cfg_sel_h, cfg_sel_t, cfg_sel_u, cfg_blank;
  sss_pos_e   scan_pos;
  logic [7:0] refresh_left;
  logic [7:0] blink_left;
  logic       blink_on;

  digit_t digits_due [$];
  digit_t predicted, due, got;
  bit     emitted;

  seven_segment_scan_blink uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .hundreds_code_i  (hundreds_code_i),
    .tens_code_i      (tens_code_i),
    .units_code_i     (units_code_i),
    .blink_mask_i     (blink_mask_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .select_byte_o    (select_byte_o),
    .segment_byte_o   (segment_byte_o),
    .digit_position_o (digit_position_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // One tick of the scan: returns 1 when a digit gets refreshed
  function automatic bit scan_tick(input logic [7:0] hund, tens, units, mask,
                                   output digit_t d);
    logic [7:0] code;
    logic [7:0] sel;
    logic [7:0] shown;
    logic [7:0] seg;
    d = '0;
    if (refresh_left != 8'd0) begin
      refresh_left = refresh_left - 8'd1;
      return 1'b0;
    end
    refresh_left = cfg_refresh;
    case (scan_pos)
      PosUnits: begin
        code = units;
        sel  = cfg_sel_u;
      end
      PosTens: begin
        code = tens;
        sel  = cfg_sel_t;
      end
      PosHundreds: begin
        code = hund;
        sel  = cfg_sel_h;
      end
      default: begin
        scan_pos = PosUnits;
        return 1'b0;
      end
    endcase
    shown = code;
    if ((mask & sel) != 8'h00) begin
      if (blink_left == 8'd0) begin
        blink_on   = ~blink_on;
        blink_left = cfg_blink;
      end else begin
        blink_left = blink_left - 8'd1;
      end
      if (!blink_on) begin
        shown = cfg_blank;
      end
    end
    seg        = (shown < GlyphCount) ? Glyphs[shown[4:0]] : 8'h00;
    d.sel_byte = {sel[7:1], seg[7]};
    d.seg_byte = {seg[6:0], 1'b0};
    d.pos      = scan_pos;
    scan_pos   = (scan_pos == PosHundreds) ? PosUnits : sss_pos_e'(scan_pos + 2'd1);
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_refresh  = 8'd2;
      cfg_blink    = 8'd50;
      cfg_sel_h    = 8'd4;
      cfg_sel_t    = 8'd2;
      cfg_sel_u    = 8'd1;
      cfg_blank    = 8'd0;
      scan_pos     = PosUnits;
      refresh_left = 8'd0;
      blink_left   = 8'd0;
      blink_on     = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRefreshReload: cfg_refresh = cfg_data_i;
          RegBlinkReload:   cfg_blink   = cfg_data_i;
          RegSelHundreds:   cfg_sel_h   = cfg_data_i;
          RegSelTens:       cfg_sel_t   = cfg_data_i;
          RegSelUnits:      cfg_sel_u   = cfg_data_i;
          RegBlankCode:     cfg_blank   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        emitted = scan_tick(hundreds_code_i, tens_code_i, units_code_i, blink_mask_i,
                            predicted);
        if (pin_on) begin
          digits_due.push_back(pin_digit);
        end else if (emitted) begin
          digits_due.push_back(predicted);
        end
      end
      if (out_valid_o && out_ready_i) begin
        got = '{select_byte_o, segment_byte_o, digit_position_o};
        if (digits_due.size() == 0) begin
          $error("digit beat with none due: select %02h segment %02h position %0d",
                 got.sel_byte, got.seg_byte, got.pos);
          mismatches++;
        end else begin
          due = digits_due.pop_front();
          if (got.sel_byte !== due.sel_byte) begin
            $error("select_byte: expected %02h, got %02h", due.sel_byte, got.sel_byte);
            mismatches++;
          end
          if (got.seg_byte !== due.seg_byte) begin
            $error("segment_byte: expected %02h, got %02h", due.seg_byte, got.seg_byte);
            mismatches++;
          end
          if (got.pos !== due.pos) begin
            $error("digit_position: expected %0d, got %0d", due.pos, got.pos);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= LongHold;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycle_count < Limit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] random_code();
    if ($urandom_range(4) == 0) begin
      return 8'($urandom_range(255));
    end
    return 8'($urandom_range(GlyphCount + 1));
  endfunction

  function automatic logic [7:0] random_select();
    if ($urandom_range(3) == 0) begin
      return 8'(1 << $urandom_range(7));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] random_mask();
    if ($urandom_range(3) == 0) begin
      return 8'h00;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_tick(input logic [7:0] hund, tens, units, mask,
                           input bit pinned, input digit_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    hundreds_code_i <= hund;
    tens_code_i     <= tens;
    units_code_i    <= units;
    blink_mask_i    <= mask;
    pin_on          <= pinned;
    pin_digit       <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every due digit, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] refresh, blink, input int unsigned idle, stall,
                           input int count, input bit long_hold);
    settle();
    idle_pct  = idle;
    stall_pct <= stall;
    cfg_write(RegRefreshReload, refresh);
    cfg_write(RegBlinkReload, blink);
    cfg_write(RegSelHundreds, random_select());
    cfg_write(RegSelTens, random_select());
    cfg_write(RegSelUnits, random_select());
    cfg_write(RegBlankCode, random_code());
    if (long_hold) begin
      hold_req <= ~hold_req;
    end
    repeat (count) begin
      send_tick(random_code(), random_code(), random_code(), random_mask(), 1'b0, '0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      if (DirRows[i].kind == RowCfg) begin
        cfg_write(DirRows[i].reg_idx, DirRows[i].reg_data);
      end else begin
        send_tick(DirRows[i].hundreds, DirRows[i].tens, DirRows[i].units,
                  DirRows[i].mask, DirRows[i].kind == RowTickPin, DirRows[i].want);
      end
    end

    run_phase(8'd0, 8'd1, 0, 0, 60, 1'b0);
    run_phase(8'd1, 8'd0, 79, 0, 70, 1'b0);
    run_phase(8'd0, 8'd3, 0, 79, 70, 1'b0);
    run_phase(8'd2, 8'd2, 32, 32, 70, 1'b0);
    // back-to-back ticks against a long output hold-off to fill the pipeline
    run_phase(8'd0, 8'd50, 0, 0, 60, 1'b1);
    run_phase(8'd255, 8'd255, 0, 0, 50, 1'b0);
    settle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
